@@ rtl/core/short_block_spread_mask_macros.svh @@
// assertion helpers for the short block spread mask
`ifndef SHORT_BLOCK_SPREAD_MASK_MACROS_SVH
`define SHORT_BLOCK_SPREAD_MASK_MACROS_SVH
// check that a condition implies a consequence in the same cycle
`define SBSM_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");
// check that a condition implies a consequence in the next cycle
`define SBSM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/sbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsm_pkg
// types and constants shared by the short block spread mask modules
// ----------------------------------------------------------------------------
package sbsm_pkg;

  // sizes of the stores
  localparam int MAX_CODER_PARTS = 12;
  localparam int NUM_BINS        = 64;
  localparam int WEIGHT_DEPTH    = 1024;

  localparam logic [1:0] REQ_PART    = 2'd0;
  localparam logic [1:0] REQ_WEIGHT  = 2'd1;
  localparam logic [1:0] REQ_ENERGY  = 2'd2;
  localparam logic [1:0] REQ_COMPUTE = 2'd3;

  localparam logic [31:0] QUIET_HALF = 32'h0000_8000;
  localparam logic [31:0] SAT_MAX    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  slot;
    logic [1:0]  block_sel;
    logic [5:0]  bin_offset;
    logic [6:0]  bin_count;
    logic [31:0] load_value;
    logic        prev_short;
  } sbsm_in_t;

  typedef struct packed {
    logic [3:0]  coder_part;
    logic [31:0] mask_first;
    logic [31:0] mask_second;
    logic [31:0] mask_third;
    logic        last;
  } sbsm_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // store a load item
    logic start_part; // never driven; the table entry is read under init_part
    logic init_sum;   // reset coder partition sums
    logic init_part;  // reset partition sums, start the bin walk from table entry
    logic acc;        // accumulate one bin
    logic add_part;   // fold partition sums into coder sums
    logic fin_a;      // clamp stage a
    logic fin_b;      // clamp stage b
    logic fin_c;      // result stage
    logic clr_widx;   // reset weight index
  } sbsm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bins_done;  // all bins of the partition consumed
  } sbsm_stat_t;

  // saturating add of two unsigned words
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT_MAX : s[31:0];
  endfunction

  // floor(x / 10) via reciprocal multiply, exact for 32-bit x
  function automatic logic [31:0] tenth(input logic [31:0] x);
    logic [66:0] p;
    p = {35'd0, x} * 67'h0_CCCC_CCCD;
    return p[66:35];
  endfunction

endpackage

@@ rtl/core/short_block_spread_mask.sv @@
// sequence: per coder partition two table reads, each followed by its bins, then clamp
// stages a and b and the result stage, which waits while the result is held by out_stall_i
// input: loads are taken while idle; a compute item stalls the input until every coder
// partition of it has been sent
// reset: saved masks clear to zero, partition_count resets to 24, stores undefined
// ----------------------------------------------------------------------------
// short_block_spread_mask
// spreading mask for three short blocks, sequencer plus datapath
// ----------------------------------------------------------------------------
`include "short_block_spread_mask_macros.svh"
module short_block_spread_mask
  import sbsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sbsm_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sbsm_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  logic [4:0] pcnt_q;
  logic       ov_q;
  sbsm_cmd_t  cmd;
  sbsm_stat_t stat;
  logic [5:0] tab_idx;
  logic [4:0] cpart;
  logic       last, busy;

  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pcnt_q <= 5'd24;
    else if (cfg_valid_i && cfg_ready_o) pcnt_q <= cfg_data_i;
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd.fin_c) ov_q <= 1'b1;
    else if (!out_stall_i) ov_q <= 1'b0;
  end
  assign out_valid_o = ov_q;

  sbsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_req_i(in_data_i.req_type),
    .part_cnt_i(pcnt_q), .out_free_i(!ov_q || !out_stall_i), .stat_i(stat),
    .in_stall_o, .cmd_o(cmd), .tab_idx_o(tab_idx), .cpart_o(cpart),
    .last_o(last), .busy_o(busy)
  );

  sbsm_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_data_i), .tab_idx_i(tab_idx),
    .cpart_i(cpart), .last_i(last), .stat_o(stat), .res_o(out_data_o)
  );

  `SBSM_ASSERT_IMPL(a_load_idle, clk_i, rst_ni, cmd.load, !busy)
  `SBSM_ASSERT_NEXT(a_fin_valid, clk_i, rst_ni, cmd.fin_c, out_valid_o)
  `SBSM_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.fin_c, !ov_q || !out_stall_i)

endmodule

@@ rtl/core/sbsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbsm_ctrl
// sequencer: walks coder partitions, model partitions and bins
// ----------------------------------------------------------------------------
module sbsm_ctrl
  import sbsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_req_i,
  input  logic [4:0] part_cnt_i,
  input  logic       out_free_i,
  input  sbsm_stat_t stat_i,
  output logic       in_stall_o,
  output sbsm_cmd_t  cmd_o,
  output logic [5:0] tab_idx_o,
  output logic [4:0] cpart_o,
  output logic       last_o,
  output logic       busy_o
);

  localparam int ModelParts = 2 * MAX_CODER_PARTS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PART = 3'd1;
  localparam logic [2:0] S_BINS = 3'd2;
  localparam logic [2:0] S_FA   = 3'd3;
  localparam logic [2:0] S_FB   = 3'd4;
  localparam logic [2:0] S_FC   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [4:0] cp_q, cp_d;
  logic       half_q, half_d;
  logic [4:0] mparts;
  logic [5:0] npart;

  // model partitions this frame, capped at ModelParts; coder partitions are half, rounded up
  always_comb begin
    npart = {1'b0, part_cnt_i};
    if (npart > 6'(ModelParts)) npart = 6'(ModelParts);
  end
  assign mparts = 5'((npart + 6'd1) >> 1);

  assign in_stall_o = (state_q != S_IDLE);
  assign busy_o     = (state_q != S_IDLE);
  assign tab_idx_o  = {cp_q, half_q};
  assign cpart_o    = cp_q;
  assign last_o     = (cp_q + 5'd1 == mparts);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cp_d    = cp_q;
    half_d  = half_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i == REQ_COMPUTE) begin
            if (npart != 6'd0) begin
              state_d = S_PART;
              cp_d = '0;
              half_d = 1'b0;
              cmd_o.clr_widx = 1'b1;
              cmd_o.init_sum = 1'b1;
            end
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_PART: begin
        cmd_o.init_part = 1'b1;
        state_d = S_BINS;
      end
      S_BINS: begin
        if (stat_i.bins_done) begin
          cmd_o.add_part = 1'b1;
          if (half_q) begin
            state_d = S_FA;
          end else begin
            half_d = 1'b1;
            state_d = S_PART;
          end
        end else begin
          cmd_o.acc = 1'b1;
        end
      end
      S_FA: begin
        cmd_o.fin_a = 1'b1;
        state_d = S_FB;
      end
      S_FB: begin
        cmd_o.fin_b = 1'b1;
        state_d = S_FC;
      end
      S_FC: begin
        if (out_free_i) begin
          cmd_o.fin_c = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (last_o) begin
          state_d = S_IDLE;
        end else begin
          cp_d = cp_q + 5'd1;
          half_d = 1'b0;
          cmd_o.init_sum = 1'b1;
          state_d = S_PART;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cp_q    <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cp_q    <= cp_d;
      half_q  <= half_d;
    end
  end

endmodule

@@ rtl/core/sbsm_dp.sv @@
// ----------------------------------------------------------------------------
// sbsm_dp
// datapath: stores, multiply accumulate, clamp and leak
// ----------------------------------------------------------------------------
module sbsm_dp
  import sbsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sbsm_cmd_t  cmd_i,
  input  sbsm_in_t   item_i,
  input  logic [5:0] tab_idx_i,
  input  logic [4:0] cpart_i,
  input  logic       last_i,
  output sbsm_stat_t stat_o,
  output sbsm_out_t  res_o
);

  localparam int TabDepth = 2 * MAX_CODER_PARTS + 1;
  localparam int TabW = $clog2(TabDepth);
  localparam int BinW = $clog2(NUM_BINS);
  localparam int WW   = $clog2(WEIGHT_DEPTH);
  localparam int CpW  = $clog2(MAX_CODER_PARTS);
  localparam int CntW = BinW + 1;

  // stores
  logic [5:0]  offs_mem [TabDepth];
  logic [6:0]  cnt_mem  [TabDepth];
  logic [15:0] w_mem    [WEIGHT_DEPTH];
  logic [31:0] e0_mem   [NUM_BINS];
  logic [31:0] e1_mem   [NUM_BINS];
  logic [31:0] e2_mem   [NUM_BINS];
  logic [31:0] saved_q  [MAX_CODER_PARTS];

  logic [WW-1:0]   widx_q;
  logic [BinW-1:0] bin_q;
  logic [CntW-1:0] left_q;
  logic            rd_v_q;
  logic [15:0]     w_rd_q;
  logic [31:0]     e_rd_q [3];
  logic [31:0]     ps_q [3];
  logic [31:0]     cs_q [3];
  logic [31:0]     k_q  [3];
  logic [31:0]     t_q  [3];
  logic [31:0]     lim_q [3];
  logic            prev_short_q;
  logic [5:0]      offs_rd;
  logic [6:0]      cnt_rd;
  logic [CntW-1:0] cnt_sat;

  // load writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      unique case (item_i.req_type)
        REQ_PART: if (item_i.slot < 10'(TabDepth)) begin
          offs_mem[item_i.slot[TabW-1:0]] <= item_i.bin_offset;
          cnt_mem[item_i.slot[TabW-1:0]]  <= item_i.bin_count;
        end
        REQ_WEIGHT: if (32'(item_i.slot) < WEIGHT_DEPTH)
          w_mem[item_i.slot[WW-1:0]] <= item_i.load_value[15:0];
        REQ_ENERGY: if (32'(item_i.slot) < NUM_BINS) begin
          if (item_i.block_sel == 2'd0) e0_mem[item_i.slot[BinW-1:0]] <= item_i.load_value;
          if (item_i.block_sel == 2'd1) e1_mem[item_i.slot[BinW-1:0]] <= item_i.load_value;
          if (item_i.block_sel == 2'd2) e2_mem[item_i.slot[BinW-1:0]] <= item_i.load_value;
        end
        default: ;
      endcase
    end
  end

  // table entry of the partition being started
  assign offs_rd = offs_mem[tab_idx_i[TabW-1:0]];
  assign cnt_rd  = cnt_mem[tab_idx_i[TabW-1:0]];
  assign cnt_sat = (cnt_rd > 7'(NUM_BINS)) ? CntW'(NUM_BINS) : CntW'(cnt_rd);

  assign stat_o.bins_done = (left_q == '0) && !rd_v_q;

  // bin walk with registered store reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      left_q <= '0;
      widx_q <= '0;
    end else begin
      if (cmd_i.clr_widx) widx_q <= '0;
      if (cmd_i.init_part) begin
        left_q <= cnt_sat;
        rd_v_q <= 1'b0;
      end else if (cmd_i.acc) begin
        rd_v_q <= (left_q != '0);
        if (left_q != '0) begin
          left_q <= left_q - CntW'(1);
          widx_q <= widx_q + WW'(1);
        end
      end else begin
        rd_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_part) bin_q <= offs_rd[BinW-1:0];
    else if (cmd_i.acc && left_q != '0) bin_q <= bin_q + BinW'(1);
    w_rd_q    <= w_mem[widx_q];
    e_rd_q[0] <= e0_mem[bin_q];
    e_rd_q[1] <= e1_mem[bin_q];
    e_rd_q[2] <= e2_mem[bin_q];
  end

  // multiply accumulate and clamp stages
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 3; b++) begin
      logic [47:0] p;
      logic [32:0] pt;
      p  = {16'd0, e_rd_q[b]} * {32'd0, w_rd_q};
      pt = p[47:15];
      if (cmd_i.init_part) ps_q[b] <= QUIET_HALF;
      else if (rd_v_q) ps_q[b] <= sat_add(ps_q[b], pt[32] ? SAT_MAX : pt[31:0]);
      if (cmd_i.init_sum) cs_q[b] <= '0;
      else if (cmd_i.add_part) cs_q[b] <= sat_add(cs_q[b], ps_q[b]);
    end
    if (cmd_i.clr_widx) prev_short_q <= item_i.prev_short;
    if (cmd_i.fin_a) begin
      t_q[0] <= tenth(cs_q[0]);
      t_q[1] <= tenth(cs_q[1]);
      t_q[2] <= tenth(cs_q[2]);
      lim_q[0] <= saved_q[cpart_i[CpW-1:0]];
      lim_q[1] <= sat_add(cs_q[0], cs_q[0]);
      lim_q[2] <= sat_add(cs_q[1], cs_q[1]);
    end
    if (cmd_i.fin_b) begin
      for (int b = 0; b < 3; b++) begin
        if (cs_q[b] <= lim_q[b] || (b == 0 && !prev_short_q)) k_q[b] <= cs_q[b];
        else k_q[b] <= (lim_q[b] > t_q[b]) ? lim_q[b] : t_q[b];
      end
    end
    if (cmd_i.fin_c) begin
      res_o.coder_part  <= cpart_i[3:0];
      res_o.mask_first  <= k_q[0];
      res_o.mask_second <= sat_add(k_q[1], tenth(k_q[0]));
      res_o.mask_third  <= sat_add(k_q[2], tenth(k_q[1]));
      res_o.last        <= last_i;
    end
  end

  // saved mask of the last frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CODER_PARTS; i++) saved_q[i] <= '0;
    end else if (cmd_i.fin_b) begin
      saved_q[cpart_i[CpW-1:0]] <= sat_add(cs_q[2], cs_q[2]);
    end
  end

endmodule
